// ----- hw/rtl/pcs_pkg.sv -----
// shared types and constants for the pixel contrast stretch block
// no dependencies; used by the top level and its checker

package pcs_pkg;

	// field and datapath widths
	localparam int PixW      = 8;
	localparam int CfgIdxW   = 2;
	localparam int QuoW      = 8;
	localparam int DenW      = PixW + 1;
	localparam int NumW      = 17;
	localparam int DivStages = QuoW;
	localparam int Stages    = 2 + DivStages;

	localparam logic [PixW-1:0] PIX_MAX = {PixW{1'b1}};

	// configuration register indices
	typedef enum logic [CfgIdxW-1:0] {
		REG_LOW  = 2'd0,
		REG_MID  = 2'd1,
		REG_HIGH = 2'd2
	} cfg_reg_t;

	// which linear segment a pixel falls in
	typedef enum logic [1:0] {
		SEG_TWO = 2'd0,
		SEG_LOW = 2'd1,
		SEG_UP  = 2'd2
	} seg_t;

	// one word travelling through the divider stages
	typedef struct packed {
		logic            force_en;
		logic            force_hi;
		logic [NumW-1:0] rem;
		logic [DenW-1:0] den;
		logic [QuoW-1:0] quo;
	} div_word_t;

endpackage

// ----- hw/rtl/pixel_contrast_stretch.sv -----
// pixel contrast stretch top level: segment select, numerator build and
// a restoring divider pipeline, one quotient bit per stage; uses pcs_pkg
//
// usage
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the low,
//   mid and high levels; cfg_ready is always high, index 3 is ignored.
//   write the levels only while no word is in flight.
//   pixel channel (pixel_valid/pixel_stall, pixel_in) takes one word per
//   clock while pixel_stall is low; result channel (result_valid/result_stall,
//   pixel_out) gives one word for each pixel, in order.
// pipeline
//   one stage for the segment compare and subtract, one for the numerator,
//   eight for the divider (one quotient bit each). one word per cycle
//   sustained while result_stall is low.
// stalls
//   each stage holds its word while the stage after it is full and
//   stalled; empty stages still fill, so pixel_stall rises only once the
//   whole ten-stage pipe is full behind a stalled result.
// reset
//   arst_n clears all valid bits and sets low 0, mid 0, high 255.

module pixel_contrast_stretch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcs_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pcs_pkg::PixW-1:0]      cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic [pcs_pkg::PixW-1:0]      pixel_in,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pcs_pkg::PixW-1:0]      pixel_out
);

	localparam int PixW   = pcs_pkg::PixW;
	localparam int NumW   = pcs_pkg::NumW;
	localparam int QuoW   = pcs_pkg::QuoW;
	localparam int DivN   = pcs_pkg::DivStages;
	localparam int Stages = pcs_pkg::Stages;

	logic [PixW-1:0] low_q, mid_q, high_q;

	logic [1:Stages] vld_s;
	logic [1:Stages] en;

	// stage one registers
	logic              force_en_s1, force_hi_s1;
	pcs_pkg::seg_t     seg_s1;
	logic [PixW-1:0]   a_s1, d_s1;

	// stage one next values
	logic              force_en_nx, force_hi_nx;
	pcs_pkg::seg_t     seg_nx;
	logic [PixW-1:0]   a_nx, d_nx;

	// stage two and divider stages
	pcs_pkg::div_word_t dw_s2, dw_nx;
	pcs_pkg::div_word_t dv_s  [0:DivN-1];
	pcs_pkg::div_word_t dv_nx [0:DivN-1];

	logic [NumW-1:0] a_w, d_w;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			mid_q  <= '0;
			high_q <= pcs_pkg::PIX_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (pcs_pkg::cfg_reg_t'(cfg_index))
				pcs_pkg::REG_LOW:  low_q  <= cfg_data;
				pcs_pkg::REG_MID:  mid_q  <= cfg_data;
				pcs_pkg::REG_HIGH: high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en[Stages] = !vld_s[Stages] || !result_stall;
		for (int k = Stages - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign pixel_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= pixel_valid;
			end
			for (int k = 2; k <= Stages; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// segment choice, offset and span; saturated ends are flagged and their quotient replaced
	always_comb begin
		force_en_nx = 1'b0;
		force_hi_nx = 1'b0;
		seg_nx      = pcs_pkg::SEG_TWO;
		a_nx        = pixel_in - low_q;
		d_nx        = high_q - low_q;
		if (pixel_in <= low_q) begin
			force_en_nx = 1'b1;
		end else if (mid_q == '0) begin
			if (pixel_in >= high_q) begin
				force_en_nx = 1'b1;
				force_hi_nx = 1'b1;
			end
		end else if (pixel_in <= mid_q) begin
			seg_nx = pcs_pkg::SEG_LOW;
			d_nx   = mid_q - low_q;
		end else if (pixel_in < high_q) begin
			seg_nx = pcs_pkg::SEG_UP;
			a_nx   = pixel_in - mid_q;
			d_nx   = high_q - mid_q;
		end else begin
			force_en_nx = 1'b1;
			force_hi_nx = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			force_en_s1 <= force_en_nx;
			force_hi_s1 <= force_hi_nx;
			seg_s1      <= seg_nx;
			a_s1        <= a_nx;
			d_s1        <= d_nx;
		end
	end

	// numerator with the rounding term folded in, denominator twice the span
	assign a_w = NumW'(a_s1);
	assign d_w = NumW'(d_s1);

	always_comb begin
		dw_nx          = '0;
		dw_nx.force_en = force_en_s1;
		dw_nx.force_hi = force_hi_s1;
		dw_nx.den      = {d_s1, 1'b0};
		case (seg_s1)
			pcs_pkg::SEG_TWO: dw_nx.rem = (a_w << 9) - (a_w << 1) + d_w;
			pcs_pkg::SEG_LOW: dw_nx.rem = (a_w << 8) + d_w;
			pcs_pkg::SEG_UP:  dw_nx.rem = (a_w << 8) + (d_w << 8) - d_w;
			default:          dw_nx.rem = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dw_s2 <= dw_nx;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	always_comb begin
		pcs_pkg::div_word_t prev;
		logic [NumW-1:0]    sh;
		for (int j = 0; j < DivN; j++) begin
			prev = (j == 0) ? dw_s2 : dv_s[j-1];
			sh   = NumW'(prev.den) << (QuoW - 1 - j);
			dv_nx[j] = prev;
			if (prev.rem >= sh) begin
				dv_nx[j].rem               = prev.rem - sh;
				dv_nx[j].quo[QuoW - 1 - j] = 1'b1;
			end
			// saturated ends replace the quotient in the last stage
			if ((j == DivN - 1) && prev.force_en) begin
				dv_nx[j].quo = prev.force_hi ? pcs_pkg::PIX_MAX : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DivN; j++) begin
			if (en[j+3]) begin
				dv_s[j] <= dv_nx[j];
			end
		end
	end

	// result word straight from the last stage
	assign result_valid = vld_s[Stages];
	assign pixel_out    = dv_s[DivN-1].quo;

endmodule

// ----- hw/rtl/pcs_checker.sv -----
// port-level checker for the pixel contrast stretch block, with its bind
// depends on pcs_pkg for the pipeline depth and pixel width

module pcs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_valid,
	input logic                          pixel_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [pcs_pkg::PixW-1:0]      pixel_out
);

	localparam int CntW = $clog2(pcs_pkg::Stages + 2);

	logic [CntW-1:0] inflight_q;
	logic            acc_in, acc_out;

	assign acc_in  = pixel_valid && !pixel_stall;
	assign acc_out = result_valid && !result_stall;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (!acc_in && acc_out) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pixel_out))
		else $error("result changed while stalled");

	// no result without a pixel behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		acc_out |-> inflight_q != '0)
		else $error("result delivered with nothing in flight");

	// never more words in flight than the pipe has stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CntW'(pcs_pkg::Stages))
		else $error("more words in flight than pipeline stages");

	// with no result waiting the pipe always takes a pixel
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !pixel_stall)
		else $error("pixel stalled while output side empty");

endmodule

bind pixel_contrast_stretch pcs_checker u_pcs_checker (.*);
